>>> design/uvs_pkg.sv
// Shared types, constants and sine table helpers for the UV sphere vertex generator.
package uvs_pkg;

    // Field widths
    localparam int CNT_W     = 9;
    localparam int CNT_MAX   = (1 << CNT_W) - 1;
    localparam int RADIUS_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NORM_W    = 16;
    localparam int POS_W     = 17;
    localparam int TEX_W     = 16;
    localparam int QB_W      = 17;
    localparam int MAG_W     = 15;

    // Divider geometry: one quotient bit per stage
    localparam int QUO_W     = 17;
    localparam int DEN_W     = CNT_W + 1;
    localparam int TEX_NUM_W = CNT_W + QUO_W + 1;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 152;

    // Parameter defaults
    localparam int MAX_SLICES_DEF       = 256;
    localparam int MAX_STACKS_DEF       = 256;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [CNT_W-1:0]    SLICES_RST = 9'd16;
    localparam logic [CNT_W-1:0]    STACKS_RST = 9'd16;

    localparam logic [MAG_W-1:0] Q15_MAX     = 15'h7FFF;
    localparam logic [63:0]      HALF_PI_Q60 = 64'h1921FB54442D1847;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_SLICES = 2'd1,
        CFG_STACKS = 2'd2
    } t_cfg_idx;

    // Quad info carried alongside the math
    typedef struct packed {
        logic [QB_W-1:0] base;
        logic            valid;
    } t_side;

    // (a*b) >> 60 in Q4.60, truncated
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl, mid;
        ah  = a >> 32;
        al  = {32'd0, a[31:0]};
        bh  = b >> 32;
        bl  = {32'd0, b[31:0]};
        mid = ah * bl + al * bh + ((al * bl) >> 32);
        return ah * bh * 64'd16 + (mid >> 28);
    endfunction

    // Shift-subtract quotient for small divisors, only used while the table is built
    function automatic logic [63:0] quo_small(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q, rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series sine of x (Q4.60), rounded to unsigned Q0.15 and capped
    function automatic logic [MAG_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0] x2, term, sum, v;
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n < 20; n++) begin
            if (term != 64'd0) begin
                term = quo_small(mul_q60(term, x2), 64'(2 * n) * 64'(2 * n + 1));
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        v = (sum + (64'd1 << 44)) >> 45;
        if (v > 64'(Q15_MAX)) begin
            v = 64'(Q15_MAX);
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

>>> design/uv_sphere_vertex_generator.sv
// Top level: UV sphere vertex generator pipeline.
//
//  channel   dir  beat contents (low bits first)
//  s_axis    in   stack_index, slice_index
//  m_axis    out  normal xyz, position xyz, tex u/v, quad base; tuser = quad_valid
//  cfg       in   index 0 radius, 1 slice_count, 2 stack_count
//
// One beat per clock in and out while the output is not held; each beat passes stage A,
// the one-bit-per-stage dividers for the phases and texture coordinates, then R, M1 and M2.
// Synchronous active-low reset clears the stage valid bits and loads register defaults.
// A held output stalls every stage at once; no beat is dropped or repeated.
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_SLICES       = MAX_SLICES_DEF,
    parameter int MAX_STACKS       = MAX_STACKS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // stack_index, slice_index
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // normal_x, normal_y, normal_z, position_x, position_y, position_z,
    // tex_u, tex_v, quad_base
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser,   // quad_valid
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW        = $clog2(SINE_TABLE_DEPTH);
    localparam int ANG_NUM_W = CNT_W + AW + 4;
    localparam int NSTG      = QUO_W + 4;
    localparam int ST_R      = QUO_W + 1;
    localparam int ST_M1     = QUO_W + 2;
    localparam int ST_OUT    = QUO_W + 3;

    localparam logic [CNT_W-1:0] SLICE_CAP =
        CNT_W'((MAX_SLICES > CNT_MAX) ? CNT_MAX : MAX_SLICES);
    localparam logic [CNT_W-1:0] STACK_CAP =
        CNT_W'((MAX_STACKS > CNT_MAX) ? CNT_MAX : MAX_STACKS);
    localparam logic [ANG_NUM_W-1:0] PHI_SCALE   = ANG_NUM_W'(4 * SINE_TABLE_DEPTH);
    localparam logic [ANG_NUM_W-1:0] THETA_SCALE = ANG_NUM_W'(8 * SINE_TABLE_DEPTH);
    localparam logic [QUO_W-1:0] D1 = QUO_W'(SINE_TABLE_DEPTH);
    localparam logic [QUO_W-1:0] D2 = QUO_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [QUO_W-1:0] D3 = QUO_W'(3 * SINE_TABLE_DEPTH);
    localparam logic [QUO_W-1:0] D4 = QUO_W'(4 * SINE_TABLE_DEPTH);
    localparam logic [TEX_NUM_W-1:0] TEX_MAX = TEX_NUM_W'(16'hFFFF);

    typedef struct packed {
        logic [AW-1:0] addr;
        logic          full;
        logic          neg;
    } t_phase;

    // Phase in quarter-table units -> table address, full-scale and sign flags
    function automatic t_phase reduce(input logic [QUO_W-1:0] p);
        logic [QUO_W-1:0] w;
        logic [QUO_W-1:0] r;
        logic [1:0]       q;
        t_phase           res;
        w = (p >= D4) ? p - D4 : p;
        if (w >= D3) begin
            q = 2'd3;
            r = w - D3;
        end else if (w >= D2) begin
            q = 2'd2;
            r = w - D2;
        end else if (w >= D1) begin
            q = 2'd1;
            r = w - D1;
        end else begin
            q = 2'd0;
            r = w;
        end
        res.neg  = q[1];
        res.full = q[0] && (r == '0);
        if (q[0]) begin
            res.addr = (r == '0) ? '0 : AW'(D1 - r);
        end else begin
            res.addr = AW'(r);
        end
        return res;
    endfunction

    // Configuration registers
    logic [RADIUS_W-1:0] r_radius;
    logic [CNT_W-1:0]    r_slice_cnt;
    logic [CNT_W-1:0]    r_stack_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_RST;
            r_slice_cnt <= SLICES_RST;
            r_stack_cnt <= STACKS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius    <= i_cfg_data;
                CFG_SLICES: r_slice_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_STACKS: r_stack_cnt <= i_cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Effective counts (zero reads as one, capped at the maximum)
    logic [CNT_W-1:0] w_slices;
    logic [CNT_W-1:0] w_stacks;

    always_comb begin
        w_slices = (r_slice_cnt == '0) ? CNT_W'(1) : r_slice_cnt;
        w_stacks = (r_stack_cnt == '0) ? CNT_W'(1) : r_stack_cnt;
        if (w_slices > SLICE_CAP) w_slices = SLICE_CAP;
        if (w_stacks > STACK_CAP) w_stacks = STACK_CAP;
    end

    // Stage valid bits and global advance
    logic [NSTG-1:0] r_vld;
    logic            w_en;

    assign w_en          = !r_vld[ST_OUT] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    // Stage A: clamp indexes, build dividends and quad info
    logic [CNT_W-1:0] w_i_raw, w_j_raw, w_i, w_j;
    logic [18:0]      w_qb_full;
    logic [ANG_NUM_W-1:0] r_a_phi_num, r_a_theta_num;
    logic [TEX_NUM_W-1:0] r_a_u_num, r_a_v_num;
    logic [DEN_W-1:0]     r_a_phi_den, r_a_theta_den;
    t_side                r_a_side;

    assign w_i_raw   = s_axis_tdata[CNT_W-1:0];
    assign w_j_raw   = s_axis_tdata[2*CNT_W-1:CNT_W];
    assign w_i       = (w_i_raw > w_stacks) ? w_stacks : w_i_raw;
    assign w_j       = (w_j_raw > w_slices) ? w_slices : w_j_raw;
    assign w_qb_full = (19'(w_slices) + 19'd1) * 19'(w_i) + 19'(w_j);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_phi_num   <= ANG_NUM_W'(w_i) * PHI_SCALE + ANG_NUM_W'(w_stacks);
            r_a_theta_num <= ANG_NUM_W'(w_j) * THETA_SCALE + ANG_NUM_W'(w_slices);
            r_a_phi_den   <= {w_stacks, 1'b0};
            r_a_theta_den <= {w_slices, 1'b0};
            r_a_u_num     <= TEX_NUM_W'({w_j, QUO_W'(0)}) + TEX_NUM_W'(w_slices);
            r_a_v_num     <= TEX_NUM_W'({w_i, QUO_W'(0)}) + TEX_NUM_W'(w_stacks);
            if ((w_i < w_stacks) && (w_j < w_slices)) begin
                r_a_side.base  <= w_qb_full[QB_W-1:0];
                r_a_side.valid <= 1'b1;
            end else begin
                r_a_side.base  <= '0;
                r_a_side.valid <= 1'b0;
            end
        end
    end

    // Divider stages
    logic [QUO_W-1:0] w_phi, w_theta, w_u, w_v;

    uvs_div_pipe #(.NUM_W(ANG_NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_phi (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_a_phi_num), .i_den(r_a_phi_den),
        .o_quo(w_phi)
    );
    uvs_div_pipe #(.NUM_W(ANG_NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_theta (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_a_theta_num), .i_den(r_a_theta_den),
        .o_quo(w_theta)
    );
    uvs_div_pipe #(.NUM_W(TEX_NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_u (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_a_u_num), .i_den(r_a_theta_den),
        .o_quo(w_u)
    );
    uvs_div_pipe #(.NUM_W(TEX_NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_v (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_a_v_num), .i_den(r_a_phi_den),
        .o_quo(w_v)
    );

    // Quad info delay line matching the dividers
    t_side r_side_dly [QUO_W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side_dly[0] <= r_a_side;
            for (int k = 1; k < QUO_W; k++) begin
                r_side_dly[k] <= r_side_dly[k-1];
            end
        end
    end

    // Stage R: phase reduction and table read
    t_phase w_ph_sp, w_ph_cp, w_ph_st, w_ph_ct;
    t_phase r_r_sp, r_r_cp, r_r_st, r_r_ct;
    logic [MAG_W-1:0] w_rom_sp, w_rom_cp, w_rom_st, w_rom_ct;
    logic [TEX_W-1:0] r_r_u, r_r_v;
    t_side            r_r_side;

    assign w_ph_sp = reduce(w_phi);
    assign w_ph_cp = reduce(w_phi + D1);
    assign w_ph_st = reduce(w_theta);
    assign w_ph_ct = reduce(w_theta + D1);

    uvs_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(AW)) u_rom_sp (
        .i_clk(i_clk), .i_en(w_en), .i_addr(w_ph_sp.addr), .o_data(w_rom_sp)
    );
    uvs_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(AW)) u_rom_cp (
        .i_clk(i_clk), .i_en(w_en), .i_addr(w_ph_cp.addr), .o_data(w_rom_cp)
    );
    uvs_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(AW)) u_rom_st (
        .i_clk(i_clk), .i_en(w_en), .i_addr(w_ph_st.addr), .o_data(w_rom_st)
    );
    uvs_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(AW)) u_rom_ct (
        .i_clk(i_clk), .i_en(w_en), .i_addr(w_ph_ct.addr), .o_data(w_rom_ct)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r_sp   <= w_ph_sp;
            r_r_cp   <= w_ph_cp;
            r_r_st   <= w_ph_st;
            r_r_ct   <= w_ph_ct;
            r_r_u    <= (TEX_NUM_W'(w_u) > TEX_MAX) ? '1 : w_u[TEX_W-1:0];
            r_r_v    <= (TEX_NUM_W'(w_v) > TEX_MAX) ? '1 : w_v[TEX_W-1:0];
            r_r_side <= r_side_dly[QUO_W-1];
        end
    end

    // Stage M1: sine products, rounded half away from zero
    logic [MAG_W-1:0] w_m_sp, w_m_cp, w_m_st, w_m_ct;
    logic [30:0]      w_px, w_pz;
    logic [MAG_W-1:0] r_m1_mag [3];
    logic [2:0]       r_m1_neg;
    logic [TEX_W-1:0] r_m1_u, r_m1_v;
    t_side            r_m1_side;

    assign w_m_sp = r_r_sp.full ? Q15_MAX : w_rom_sp;
    assign w_m_cp = r_r_cp.full ? Q15_MAX : w_rom_cp;
    assign w_m_st = r_r_st.full ? Q15_MAX : w_rom_st;
    assign w_m_ct = r_r_ct.full ? Q15_MAX : w_rom_ct;
    assign w_px   = 31'(w_m_sp) * 31'(w_m_ct) + 31'(1 << 14);
    assign w_pz   = 31'(w_m_sp) * 31'(w_m_st) + 31'(1 << 14);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_mag[0] <= w_px[29:15];
            r_m1_mag[1] <= w_m_cp;
            r_m1_mag[2] <= w_pz[29:15];
            r_m1_neg    <= {r_r_sp.neg ^ r_r_st.neg, r_r_cp.neg, r_r_sp.neg ^ r_r_ct.neg};
            r_m1_u      <= r_r_u;
            r_m1_v      <= r_r_v;
            r_m1_side   <= r_r_side;
        end
    end

    // Stage M2 / output register: scale by radius
    logic signed [NORM_W-1:0] r_o_norm [3];
    logic signed [POS_W-1:0]  r_o_pos  [3];
    logic [TEX_W-1:0]         r_o_u, r_o_v;
    t_side                    r_o_side;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [31:0]      w_prod;
        logic [POS_W-1:0] w_pmag;
        assign w_prod = 32'(r_m1_mag[a]) * 32'(r_radius) + 32'(1 << 14);
        assign w_pmag = w_prod[31:15];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_o_norm[a] <= r_m1_neg[a] ? -$signed(NORM_W'(r_m1_mag[a]))
                                           : $signed(NORM_W'(r_m1_mag[a]));
                r_o_pos[a]  <= r_m1_neg[a] ? -$signed(w_pmag) : $signed(w_pmag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_u    <= r_m1_u;
            r_o_v    <= r_m1_v;
            r_o_side <= r_m1_side;
        end
    end

    assign m_axis_tdata = {4'd0, r_o_side.base, r_o_v, r_o_u,
                           r_o_pos[2], r_o_pos[1], r_o_pos[0],
                           r_o_norm[2], r_o_norm[1], r_o_norm[0]};
    assign m_axis_tuser = r_o_side.valid;

endmodule

>>> design/uvs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
module uvs_div_pipe
    import uvs_pkg::*;
#(
    parameter int NUM_W = TEX_NUM_W,
    parameter int DW    = DEN_W,
    parameter int QW    = QUO_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QW-1:0]    o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stg
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_low_in;
        logic [QW-1:0] w_quo_in;
        logic [DW:0]   w_trial;

        // Upper numerator bits seed the remainder; quotient fits QW bits
        if (s == 0) begin : g_first
            assign w_rem_in = DW'(i_num >> QW);
            assign w_den_in = i_den;
            assign w_low_in = i_num[QW-1:0];
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_low_in = r_low[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        assign w_trial = {w_rem_in, w_low_in[QW-1-s]};

        // Trial subtract, keep or restore
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_trial >= {1'b0, w_den_in}) begin
                    r_rem[s] <= DW'(w_trial - {1'b0, w_den_in});
                    r_quo[s] <= w_quo_in | (QW'(1) << (QW - 1 - s));
                end else begin
                    r_rem[s] <= w_trial[DW-1:0];
                    r_quo[s] <= w_quo_in;
                end
                r_den[s] <= w_den_in;
                r_low[s] <= w_low_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

>>> design/uvs_sine_rom.sv
// Quarter-wave sine table in unsigned Q0.15 with registered read.
module uvs_sine_rom
    import uvs_pkg::*;
#(
    parameter int DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(SINE_TABLE_DEPTH_DEF)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_addr,
    output logic [MAG_W-1:0] o_data
);

    logic [MAG_W-1:0] w_lut [DEPTH];
    logic [MAG_W-1:0] r_data;

    // Table contents fixed at elaboration
    for (genvar k = 0; k < DEPTH; k++) begin : g_lut
        localparam logic [63:0] ANGLE = (HALF_PI_Q60 / 64'(DEPTH)) * 64'(k)
                                      + ((HALF_PI_Q60 % 64'(DEPTH)) * 64'(k)) / 64'(DEPTH);
        localparam logic [MAG_W-1:0] VAL = sine_entry(ANGLE);
        assign w_lut[k] = VAL;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_lut[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

>>> design/uvs_checker.sv
// Port-level checks for the UV sphere vertex generator, bound to the top level.
module uvs_checker
    import uvs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // Stalled output beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // Input side only waits on a held output beat
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // No quad means a zero base index
    a_quad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[147:131] == '0)
        else $error("quad base nonzero without quad");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the UV sphere vertex generator.
module tb_top;
    import uvs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = SINE_TABLE_DEPTH_DEF;
    localparam int DRAIN_CYC = 30;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // stack_index, slice_index
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // normal_x, normal_y, normal_z, position_x, position_y, position_z,
    // tex_u, tex_v, quad_base
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;   // quad_valid
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    typedef struct packed {
        logic [NORM_W-1:0] nx, ny, nz;
        logic [POS_W-1:0]  px, py, pz;
        logic [TEX_W-1:0]  tu, tv;
        logic [QB_W-1:0]   qbase;
        logic              qvalid;
    } t_vertex;

    t_vertex     vertex_q[$];
    int          quarter_sine[DEPTH];
    int unsigned radius_q88, slices_reg, stacks_reg;
    int          fail_cnt, sent_cnt, seen_cnt, hold_req, burst_left;

    uv_sphere_vertex_generator u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3ms;
        $display("uv_sphere_vertex_generator regression: fail");
        $finish;
    end

    // quarter-wave sine, Taylor series in Q4.60
    function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic void build_sine();
        longint unsigned x, x2, term, acc, v;
        for (int k = 0; k < DEPTH; k++) begin
            x = (HALF_PI_Q60 / DEPTH) * k + ((HALF_PI_Q60 % DEPTH) * k) / DEPTH;
            x2 = q60_mul(x, x);
            term = x;
            acc = x;
            for (int n = 1; n < 20 && term != 0; n++) begin
                term = q60_mul(term, x2) / ((2 * n) * (2 * n + 1));
                if (n % 2) acc = acc - term;
                else acc = acc + term;
            end
            v = (acc + (64'd1 << 44)) >> 45;
            quarter_sine[k] = (v > 32767) ? 32767 : int'(v);
        end
    endfunction

    function automatic int sine_at(longint unsigned ph);
        longint unsigned q, r;
        int m;
        ph = ph % (4 * DEPTH);
        q = ph / DEPTH;
        r = ph % DEPTH;
        if (q % 2) m = (r == 0) ? 32767 : quarter_sine[DEPTH - r];
        else m = quarter_sine[r];
        return (q >= 2) ? -m : m;
    endfunction

    // product rounded half away from zero
    function automatic int prod_round(int a, int b, int sh);
        longint ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb + (64'sd1 <<< (sh - 1))) >>> sh;
        return int'(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    function automatic int unsigned tex_q16(longint unsigned n, longint unsigned cnt);
        longint unsigned v;
        v = (n * 131072 + cnt) / (2 * cnt);
        return (v > 65535) ? 65535 : int'(v);
    endfunction

    function automatic t_vertex vertex_expect(int unsigned si, int unsigned sj);
        t_vertex e;
        longint unsigned sl, st, i, j, phi, th;
        int sp, cp, sn, cn, nrm[3];
        sl = (slices_reg == 0) ? 1 : (slices_reg > 256 ? 256 : slices_reg);
        st = (stacks_reg == 0) ? 1 : (stacks_reg > 256 ? 256 : stacks_reg);
        i = (si > st) ? st : si;
        j = (sj > sl) ? sl : sj;
        phi = (i * 4 * DEPTH + st) / (2 * st);
        th = (j * 8 * DEPTH + sl) / (2 * sl);
        sp = sine_at(phi);
        cp = sine_at(phi + DEPTH);
        sn = sine_at(th);
        cn = sine_at(th + DEPTH);
        nrm[0] = prod_round(sp, cn, 15);
        nrm[1] = cp;
        nrm[2] = prod_round(sp, sn, 15);
        e.nx = nrm[0][15:0];
        e.ny = nrm[1][15:0];
        e.nz = nrm[2][15:0];
        e.px = 17'(prod_round(nrm[0], int'(radius_q88), 15));
        e.py = 17'(prod_round(nrm[1], int'(radius_q88), 15));
        e.pz = 17'(prod_round(nrm[2], int'(radius_q88), 15));
        e.tu = 16'(tex_q16(j, sl));
        e.tv = 16'(tex_q16(i, st));
        e.qvalid = (i < st) && (j < sl);
        e.qbase = e.qvalid ? 17'((sl + 1) * i + j) : '0;
        return e;
    endfunction

    task automatic cmp_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            fail_cnt++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v,
                     act_v);
        end
    endtask

    // output side: checks every beat, stalls on its own pattern
    always @(posedge i_clk) begin
        t_vertex e;
        int phase;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_cnt++;
            if (vertex_q.size() == 0) begin
                fail_cnt++;
                $display("%0t ns: unexpected vertex beat 0x%0h", $time, m_axis_tdata);
            end else begin
                e = vertex_q.pop_front();
                cmp_field("normal_x", e.nx, m_axis_tdata[15:0]);
                cmp_field("normal_y", e.ny, m_axis_tdata[31:16]);
                cmp_field("normal_z", e.nz, m_axis_tdata[47:32]);
                cmp_field("position_x", e.px, m_axis_tdata[64:48]);
                cmp_field("position_y", e.py, m_axis_tdata[81:65]);
                cmp_field("position_z", e.pz, m_axis_tdata[98:82]);
                cmp_field("tex_u", e.tu, m_axis_tdata[114:99]);
                cmp_field("tex_v", e.tv, m_axis_tdata[130:115]);
                cmp_field("quad_base", e.qbase, m_axis_tdata[147:131]);
                cmp_field("quad_valid", e.qvalid, m_axis_tuser);
            end
        end
        phase = ($time / 2000) % 3;
        if (hold_req > 0) begin
            hold_req--;
            m_axis_tready <= 1'b0;
        end else if (phase == 0) begin
            m_axis_tready <= 1'b1;
        end else if (phase == 1) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_axis_tready <= ($urandom_range(0, 1) != 0);
        end
    end

    // send one grid point, in bursts with random gaps
    task automatic send_point(int unsigned si, int unsigned sj);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, 9'(sj), 9'(si)};
        do @(posedge i_clk); while (!s_axis_tready);
        vertex_q.push_back(vertex_expect(si & 9'h1FF, sj & 9'h1FF));
        sent_cnt++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_RADIUS: radius_q88 = val & 16'hFFFF;
            CFG_SLICES: slices_reg = val & 9'h1FF;
            CFG_STACKS: stacks_reg = val & 9'h1FF;
            default: ;
        endcase
    endtask

    task automatic rand_point();
        int unsigned si, sj;
        if ($urandom_range(0, 9) == 0) begin
            si = $urandom_range(0, 511);
            sj = $urandom_range(0, 511);
        end else begin
            si = $urandom_range(0, stacks_reg + 1);
            sj = $urandom_range(0, slices_reg + 1);
        end
        send_point(si, sj);
    endtask

    // poles, equator, edges and clamping at reset settings
    task automatic test_directed();
        send_point(0, 0);
        send_point(16, 16);
        send_point(8, 4);
        send_point(8, 12);
        send_point(15, 15);
        send_point(511, 511);
        send_point(17, 3);
        send_point(4, 300);
        send_point(0, 8);
        send_point(16, 0);
        send_point(1, 1);
        send_point(9'h155, 9'h0AA);
        send_point(9'h0AA, 9'h155);
        wait_idle();
    endtask

    // count and radius extremes, zero and oversized counts, unknown register
    task automatic test_config_extremes();
        write_reg(CFG_RADIUS, 16'hFFFF);
        write_reg(CFG_SLICES, 0);
        write_reg(CFG_STACKS, 0);
        send_point(0, 0);
        send_point(1, 1);
        send_point(2, 2);
        wait_idle();
        write_reg(CFG_RADIUS, 0);
        write_reg(CFG_SLICES, 511);
        write_reg(CFG_STACKS, 256);
        send_point(255, 255);
        send_point(256, 256);
        send_point(128, 64);
        wait_idle();
        // writes to an unmapped index must leave the registers alone
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_UNMAPPED;
        i_cfg_data <= 16'h0003;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        send_point(200, 100);
        send_point(3, 3);
        wait_idle();
    endtask

    // random points over a range of settings
    task automatic test_random_sweep();
        int unsigned rads[6] = '{256, 0, 65535, 1, 32768, 12345};
        for (int s = 0; s < 6; s++) begin
            write_reg(CFG_RADIUS, (s < 5) ? rads[s] : $urandom_range(0, 65535));
            write_reg(CFG_SLICES, (s == 1) ? 1 : (s == 2) ? 256 : $urandom_range(1, 300));
            write_reg(CFG_STACKS, (s == 1) ? 256 : (s == 2) ? 1 : $urandom_range(1, 300));
            repeat (280) rand_point();
            wait_idle();
        end
    endtask

    // long output stall fills the pipe; then a mid-stream pause until empty
    task automatic test_backpressure();
        write_reg(CFG_SLICES, 32);
        write_reg(CFG_STACKS, 24);
        write_reg(CFG_RADIUS, 16'h0180);
        hold_req = 120;
        repeat (120) rand_point();
        s_axis_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        repeat (120) rand_point();
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_RADIUS;
        i_cfg_data = '0;
        radius_q88 = 256;
        slices_reg = 16;
        stacks_reg = 16;
        build_sine();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random_sweep();
        test_backpressure();

        $display("Covered %0d grid points, %0d vertices checked, over radius and count",
                 sent_cnt, seen_cnt);
        $display("extremes, index clamping, bursty input and a long output stall.");
        if (fail_cnt == 0 && vertex_q.size() == 0) begin
            $display("uv_sphere_vertex_generator regression: pass");
        end else begin
            $display("%0d mismatches, %0d vertices never arrived", fail_cnt, vertex_q.size());
            $display("uv_sphere_vertex_generator regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/uvs_pkg.sv
design/uvs_div_pipe.sv
design/uvs_sine_rom.sv
design/uv_sphere_vertex_generator.sv
design/uvs_checker.sv
sim/tb_top.sv
